/* design/sil_pkg.sv */
// Shared types, constants and codes for the sorted interval lookup block.
package sil_pkg;

   localparam int unsigned TABLE_DEPTH_DEFAULT = 4096;
   localparam int unsigned ADDR_W = 64;
   localparam int unsigned INDEX_W = 12;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned CMD_W = 2;
   localparam int unsigned JOB_QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TRACE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_LOADED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BELOW = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SAME = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NEW = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FOUND = 3'd5;
   localparam logic [STATUS_W-1:0] ST_MISS = 3'd6;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  region_index;
      logic [ADDR_W-1:0]   region_start;
      logic [ADDR_W-1:0]   region_end;
   } rsp_type;

endpackage

/* design/sil_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sil_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/sil_front.sv */
// Front end: accepts words, drops unknown commands, queues jobs for the back end.
module sil_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  sil_pkg::req_type req_item,
   output logic             req_full,
   output logic             job_valid,
   output sil_pkg::req_type job_item,
   input  logic             job_pop
);

   localparam int unsigned QD = sil_pkg::JOB_QUEUE_DEPTH;
   localparam int unsigned PW = $clog2(QD);
   localparam int unsigned FW = $clog2(QD + 1);

   sil_pkg::req_type slot_ff [QD];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          accept;
   logic          known;
   logic          push_q;
   logic          pop_q;

   assign req_full  = (fill_ff == FW'(QD));
   assign accept    = req_push && !req_full;
   assign known     = (req_item.command == sil_pkg::CMD_LOAD)
                   || (req_item.command == sil_pkg::CMD_TRACE)
                   || (req_item.command == sil_pkg::CMD_LOOKUP);
   // unknown commands are taken and dropped without a result
   assign push_q    = accept && known;
   assign job_valid = (fill_ff != '0);
   assign pop_q     = job_pop && job_valid;
   assign job_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_q) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QD - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_q) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QD - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_q, pop_q})
         2'b10: begin
            fill_in = fill_ff + 1'b1;
         end
         2'b01: begin
            fill_in = fill_ff - 1'b1;
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

/* design/sil_back.sv */
// Back end: table store, last-region cache, binary search sequencer, result register.
module sil_back #(
   parameter int unsigned TABLE_DEPTH = sil_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  sil_pkg::req_type job_item,
   output logic             job_pop,
   output logic             rsp_empty,
   output sil_pkg::rsp_type rsp_item,
   input  logic             rsp_pop
);

   localparam int unsigned IW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned AW = sil_pkg::ADDR_W;
   localparam int unsigned XW = sil_pkg::INDEX_W;

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_SEARCH  = 4'b0010,
      S_FETCH   = 4'b0100,
      S_RESOLVE = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    entry0_ff, entry0_in;
   logic             cache_valid_ff, cache_valid_in;
   logic [XW-1:0]    cached_index_ff, cached_index_in;
   logic [AW-1:0]    cached_start_ff, cached_start_in;
   logic [AW-1:0]    cached_end_ff, cached_end_in;
   logic             is_trace_ff, is_trace_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [IW-1:0]    lo_ff, lo_in;
   logic [IW-1:0]    hi_ff, hi_in;
   logic [IW-1:0]    mid_ff, mid_in;
   logic [AW-1:0]    start_ff, start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sil_pkg::rsp_type rsp_ff, rsp_in;

   logic             out_free;
   logic             table_full;
   logic [IW-1:0]    count_last;
   logic [IW-1:0]    init_mid;
   logic             below;
   logic             cache_hit;
   logic             go_right;
   logic [IW-1:0]    nlo;
   logic [IW-1:0]    nhi;
   logic [IW:0]      nsum;
   logic [IW-1:0]    nmid;
   logic             hit;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [IW-1:0]    rd_addr;
   logic [AW-1:0]    rd_data;

   sil_ram #(
      .WIDTH (AW),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (job_item.address),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_pop;
   assign job_pop    = (state_ff == S_IDLE) && job_valid && out_free;
   assign table_full = (count_ff >= CW'(TABLE_DEPTH));
   assign count_last = IW'(count_ff - 1'b1);
   assign init_mid   = count_last >> 1;
   assign below      = (job_item.address < entry0_ff);
   assign cache_hit  = cache_valid_ff && (job_item.address >= cached_start_ff)
                    && (job_item.address <= cached_end_ff);

   // one probe per cycle: rd_data holds entry[mid+1] for the current bounds
   assign go_right = (rd_data < addr_ff);
   assign nlo      = go_right ? mid_ff + 1'b1 : lo_ff;
   assign nhi      = go_right ? hi_ff : mid_ff;
   assign nsum     = {1'b0, nlo} + {1'b0, nhi};
   assign nmid     = nsum[IW:1];

   // a final lo on the last entry has no region above it
   assign hit = (lo_ff != count_last) && (start_ff <= addr_ff);

   assign wr_en   = job_pop && (job_item.command == sil_pkg::CMD_LOAD) && !table_full;
   assign wr_addr = IW'(count_ff);

   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = init_mid + 1'b1;
         end
         S_SEARCH: begin
            rd_addr = (nlo < nhi) ? nmid + 1'b1 : nlo;
         end
         default: begin
            rd_addr = lo_ff + 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      entry0_in       = entry0_ff;
      cache_valid_in  = cache_valid_ff;
      cached_index_in = cached_index_ff;
      cached_start_in = cached_start_ff;
      cached_end_in   = cached_end_ff;
      is_trace_in     = is_trace_ff;
      addr_in         = addr_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      start_in        = start_ff;
      rsp_valid_in    = rsp_pop ? 1'b0 : rsp_valid_ff;
      rsp_in          = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (job_pop) begin
               addr_in     = job_item.address;
               is_trace_in = (job_item.command == sil_pkg::CMD_TRACE);
               rsp_in      = '0;
               unique case (job_item.command)
                  sil_pkg::CMD_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (table_full) begin
                        rsp_in.status = sil_pkg::ST_FULL;
                     end else begin
                        rsp_in.status       = sil_pkg::ST_LOADED;
                        rsp_in.region_index = XW'(count_ff);
                        rsp_in.region_start = job_item.address;
                        count_in            = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           entry0_in = job_item.address;
                        end
                     end
                  end
                  sil_pkg::CMD_TRACE, sil_pkg::CMD_LOOKUP: begin
                     priority if (count_ff == '0 && is_trace_in) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = sil_pkg::ST_MISS;
                     end else if (is_trace_in && below) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = sil_pkg::ST_BELOW;
                     end else if (is_trace_in && cache_hit) begin
                        rsp_valid_in        = 1'b1;
                        rsp_in.status       = sil_pkg::ST_SAME;
                        rsp_in.region_index = cached_index_ff;
                        rsp_in.region_start = cached_start_ff;
                        rsp_in.region_end   = cached_end_ff;
                     end else if (count_ff < CW'(2)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = sil_pkg::ST_MISS;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_last;
                        mid_in   = init_mid;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_pop;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            lo_in  = nlo;
            hi_in  = nhi;
            mid_in = nmid;
            if (!(nlo < nhi)) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            start_in = rd_data;
            state_in = S_RESOLVE;
         end
         default: begin
            // slot was reserved at dispatch, so the result always lands
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            if (hit) begin
               rsp_in.status       = is_trace_ff ? sil_pkg::ST_NEW : sil_pkg::ST_FOUND;
               rsp_in.region_index = XW'(lo_ff);
               rsp_in.region_start = start_ff;
               rsp_in.region_end   = rd_data;
               if (is_trace_ff) begin
                  cache_valid_in  = 1'b1;
                  cached_index_in = XW'(lo_ff);
                  cached_start_in = start_ff;
                  cached_end_in   = rd_data;
               end
            end else begin
               rsp_in.status = sil_pkg::ST_MISS;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         cache_valid_ff  <= 1'b0;
         cached_index_ff <= '0;
         cached_start_ff <= '0;
         cached_end_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         cache_valid_ff  <= cache_valid_in;
         cached_index_ff <= cached_index_in;
         cached_start_ff <= cached_start_in;
         cached_end_ff   <= cached_end_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry0_ff   <= entry0_in;
      is_trace_ff <= is_trace_in;
      addr_ff     <= addr_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      start_ff    <= start_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* design/sorted_interval_lookup_with_cache.sv */
// Top level: sorted region table with binary search and a last-region cache.
//
// Input queue: write a word (command, address) with req_push while req_full is
// low. Load appends an entry, trace query locates an address and refreshes
// the cache, plain lookup locates without touching the cache. Unknown
// commands are taken and dropped with no result.
// Result queue: while rsp_empty is low the oldest result sits on rsp_item;
// pulse rsp_pop to take it. One result per known command, in order.
// A two-word job queue sits between the front end and the search engine, so
// input words are taken while the result register waits for rsp_pop; req_full
// rises whenever the job queue holds two words.
// Engine: a load, a below-table trace, a cache hit or a table of fewer than
// two entries is answered straight from the idle state. A search walks the
// probe, fetch and resolve states, its probes paced by the one read port of
// the table RAM, probed once per cycle.
// Reset (synchronous) empties both queues, the table count and the cache;
// table contents are not cleared, there is no clearing pass.
module sorted_interval_lookup_with_cache #(
   parameter int unsigned TABLE_DEPTH = sil_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  sil_pkg::req_type req_item,
   output logic             req_full,
   output logic             rsp_empty,
   output sil_pkg::rsp_type rsp_item,
   input  logic             rsp_pop
);

   logic             job_valid;
   logic             job_pop;
   sil_pkg::req_type job_item;

   sil_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .job_valid (job_valid),
      .job_item  (job_item),
      .job_pop   (job_pop)
   );

   sil_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_item  (job_item),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item),
      .rsp_pop   (rsp_pop)
   );

endmodule

/* design/sil_checker.sv */
// Port-level checker for the sorted interval lookup block, bound to the top level.
module sil_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input sil_pkg::rsp_type rsp_item,
   input logic             rsp_pop
);

   a_reset_empty: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("stalled result word changed or vanished");

   a_no_region_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_item.status == sil_pkg::ST_FULL
                   || rsp_item.status == sil_pkg::ST_BELOW
                   || rsp_item.status == sil_pkg::ST_MISS))
      |-> (rsp_item.region_index == '0 && rsp_item.region_start == '0
           && rsp_item.region_end == '0))
      else $error("region fields set on a result without a region");

   a_region_bounds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_item.status == sil_pkg::ST_SAME
                   || rsp_item.status == sil_pkg::ST_NEW
                   || rsp_item.status == sil_pkg::ST_FOUND))
      |-> (rsp_item.region_start <= rsp_item.region_end))
      else $error("found region has start above end");

   a_load_no_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.status == sil_pkg::ST_LOADED)
      |-> (rsp_item.region_end == '0))
      else $error("load result carries a region end");

endmodule

bind sorted_interval_lookup_with_cache sil_port_checker u_sil_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_item  (rsp_item),
   .rsp_pop   (rsp_pop)
);

/* tb/sv/sil_checker.sv */
// Checker for the interval lookup block: predicts every result word and compares it.
module sil_checker #(
   parameter int unsigned TABLE_DEPTH = sil_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  sil_pkg::req_type req_item,
   input  logic             req_full,
   input  logic             rsp_empty,
   input  sil_pkg::rsp_type rsp_item,
   input  logic             rsp_pop,
   output int               mismatch_count,
   output int               results_pending
);
   import sil_pkg::*;

   logic [ADDR_W-1:0]  entry_table [TABLE_DEPTH];
   int unsigned        entry_total;
   bit                 cache_live;
   logic [INDEX_W-1:0] cache_index;
   logic [ADDR_W-1:0]  cache_start;
   logic [ADDR_W-1:0]  cache_end;
   rsp_type            expected_regions [$];

   // Lowest-index region whose inclusive bounds hold the address, by binary search; exact only for sorted contents.
   function automatic bit find_region(input logic [ADDR_W-1:0] addr,
                                      output int unsigned idx);
      int unsigned lo, hi, mid;
      idx = 0;
      if (entry_total < 2) return 1'b0;
      lo = 0;
      hi = entry_total - 1;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (entry_table[mid + 1] < addr) lo = mid + 1;
         else hi = mid;
      end
      if (lo >= entry_total - 1 || entry_table[lo] > addr) return 1'b0;
      idx = lo;
      return 1'b1;
   endfunction

   task automatic predict_region_word(input req_type w);
      rsp_type     r;
      int unsigned idx;
      r = '0;
      idx = 0;
      case (w.command)
         CMD_LOAD: begin
            if (entry_total >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               entry_table[entry_total] = w.address;
               r.status = ST_LOADED;
               r.region_index = INDEX_W'(entry_total);
               r.region_start = w.address;
               entry_total++;
            end
            expected_regions.push_back(r);
         end
         CMD_TRACE: begin
            if (entry_total == 0) begin
               r.status = ST_MISS;
            end else if (w.address < entry_table[0]) begin
               r.status = ST_BELOW;
            end else if (cache_live && w.address >= cache_start && w.address <= cache_end) begin
               r.status = ST_SAME;
               r.region_index = cache_index;
               r.region_start = cache_start;
               r.region_end = cache_end;
            end else if (find_region(w.address, idx)) begin
               cache_live = 1'b1;
               cache_index = INDEX_W'(idx);
               cache_start = entry_table[idx];
               cache_end = entry_table[idx + 1];
               r.status = ST_NEW;
               r.region_index = cache_index;
               r.region_start = cache_start;
               r.region_end = cache_end;
            end else begin
               r.status = ST_MISS;
            end
            expected_regions.push_back(r);
         end
         CMD_LOOKUP: begin
            if (find_region(w.address, idx)) begin
               r.status = ST_FOUND;
               r.region_index = INDEX_W'(idx);
               r.region_start = entry_table[idx];
               r.region_end = entry_table[idx + 1];
            end else begin
               r.status = ST_MISS;
            end
            expected_regions.push_back(r);
         end
         default: ; // unused command: dropped, no result
      endcase
   endtask

   task automatic compare_region_word(input rsp_type got);
      rsp_type want;
      if (expected_regions.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result word: status %0d index %0d start %h end %h",
                     got.status, got.region_index, got.region_start, got.region_end);
      end else begin
         want = expected_regions.pop_front();
         if (got.status !== want.status || got.region_index !== want.region_index ||
             got.region_start !== want.region_start || got.region_end !== want.region_end) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result mismatch: expected status %0d index %0d start %h end %h, got status %0d index %0d start %h end %h",
                        want.status, want.region_index, want.region_start, want.region_end,
                        got.status, got.region_index, got.region_start, got.region_end);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         entry_total = 0;
         cache_live = 1'b0;
         cache_index = '0;
         cache_start = '0;
         cache_end = '0;
         expected_regions.delete();
      end else begin
         // Take the result first: a word popped now left the block before this edge.
         if (rsp_pop && !rsp_empty) compare_region_word(rsp_item);
         if (req_push && !req_full) predict_region_word(req_item);
      end
      results_pending <= expected_regions.size();
   end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top: drives region loads and queries into the lookup block and gives the verdict.
module tb_top;
   import sil_pkg::*;

   localparam int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned HOLD_CYCLES = 300;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_item = '0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_item;
   logic    rsp_pop = 1'b0;
   int      mismatch_count;
   int      results_pending;

   // Stimulus bookkeeping: what has been loaded so far, to aim queries at it.
   logic [ADDR_W-1:0] entry_shadow [TABLE_DEPTH];
   int unsigned       shadow_count = 0;
   logic [ADDR_W-1:0] ascend_floor = '0;
   logic [ADDR_W-1:0] last_trace_addr = '0;
   bit                sender_idles = 1'b0;
   bit                receiver_stalls = 1'b0;
   bit                hold_due = 1'b0;

   sorted_interval_lookup_with_cache #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item),
      .rsp_pop   (rsp_pop)
   );

   sil_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_item        (req_item),
      .req_full        (req_full),
      .rsp_empty       (rsp_empty),
      .rsp_item        (rsp_item),
      .rsp_pop         (rsp_pop),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Mostly short gaps, a few long ones.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Ascending start addresses with duplicates and tight gaps; a few out of order.
   function automatic logic [ADDR_W-1:0] next_entry_value();
      logic [ADDR_W-1:0] v;
      int unsigned       r;
      if (shadow_count == TABLE_DEPTH - 1) return '1;
      r = $urandom_range(0, 99);
      if (r < 3) return {$urandom, $urandom};
      if (r < 15) v = ascend_floor;
      else if (r < 27) v = ascend_floor + $urandom_range(1, 3);
      else v = {INDEX_W'(shadow_count), 20'($urandom), $urandom};
      if (v < ascend_floor) v = ascend_floor;
      ascend_floor = v;
      return v;
   endfunction

   function automatic logic [ADDR_W-1:0] query_address();
      int unsigned r, j;
      r = $urandom_range(0, 99);
      if (shadow_count == 0 || r < 10) return {$urandom, $urandom};
      j = $urandom_range(0, shadow_count - 1);
      if (r < 25) return last_trace_addr + $urandom_range(0, 3);
      if (r < 40) return entry_shadow[j];
      if (r < 50) return entry_shadow[j] - 1;
      if (r < 60) return entry_shadow[j] + 1;
      return entry_shadow[j] + ({$urandom, $urandom} >> $urandom_range(8, 63));
   endfunction

   task automatic push_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
      req_type     w;
      int unsigned gap;
      w.command = cmd;
      w.address = addr;
      req_push <= 1'b1;
      req_item <= w;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (cmd == CMD_LOAD && shadow_count < TABLE_DEPTH) begin
         entry_shadow[shadow_count] = addr;
         shadow_count++;
      end
      gap = sender_idles ? idle_length() : 0;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic push_random_query();
      logic [ADDR_W-1:0] a;
      int unsigned       pick;
      pick = $urandom_range(0, 99);
      a = query_address();
      if (pick < 2) begin
         push_word(CMD_UNUSED, a);
      end else if (pick < 60) begin
         last_trace_addr = a;
         push_word(CMD_TRACE, a);
      end else begin
         push_word(CMD_LOOKUP, a);
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   // Receiver: random pops, plus one long hold-off so the block backs up.
   initial begin
      bit          hold_done;
      int unsigned gap;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_due && !hold_done) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         gap = receiver_stalls ? idle_length() : 0;
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      int unsigned growth_target [8];
      int unsigned phase, k;
      growth_target = '{4, 6, 10, 24, 48, 96, 180, 300};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table, single entry, a two-entry table, then a third entry that makes a zero-length region.
      push_word(CMD_TRACE, '0);
      push_word(CMD_LOOKUP, '1);
      push_word(CMD_UNUSED, '1);
      push_word(CMD_LOAD, 64'h1000);
      push_word(CMD_TRACE, '0);
      push_word(CMD_TRACE, 64'h1000);
      push_word(CMD_LOOKUP, 64'h1000);
      push_word(CMD_LOAD, 64'h2000);
      push_word(CMD_TRACE, 64'h1000);
      push_word(CMD_TRACE, 64'h2000);
      push_word(CMD_TRACE, 64'h17ff);
      push_word(CMD_LOOKUP, 64'h1fff);
      push_word(CMD_LOOKUP, 64'h2001);
      push_word(CMD_TRACE, 64'h2001);
      push_word(CMD_TRACE, 64'h1800);
      push_word(CMD_LOAD, 64'h2000);
      push_word(CMD_TRACE, 64'h2000);
      push_word(CMD_LOOKUP, 64'h2000);
      push_word(CMD_TRACE, 64'h0fff);
      push_word(CMD_TRACE, '1);
      wait_drained();
      ascend_floor = 64'h2000;

      // Grow the table in steps, draining between steps.
      for (phase = 0; phase < 8; phase++) begin
         sender_idles = (phase != 3) && ($urandom_range(0, 3) != 0);
         receiver_stalls <= ($urandom_range(0, 3) != 0);
         if (phase == 3) hold_due <= 1'b1;
         for (k = 0; k < 150; k++) begin
            if (shadow_count < growth_target[phase] && $urandom_range(0, 2) == 0)
               push_word(CMD_LOAD, next_entry_value());
            else
               push_random_query();
         end
         wait_drained();
      end

      // End the table with the all-ones marker, then deep searches and stray loads.
      push_word(CMD_LOAD, '1);
      sender_idles = 1'b1;
      receiver_stalls <= 1'b1;
      push_word(CMD_LOAD, {$urandom, $urandom});
      for (k = 0; k < 250; k++) begin
         if ($urandom_range(0, 49) == 0) push_word(CMD_LOAD, {$urandom, $urandom});
         else push_random_query();
      end
      wait_drained();
      repeat (40) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
